FILE: design/ced_pkg.sv
// Shared types, character constants and small decode helpers for the C escape
// sequence decoder. It depends on nothing else. The decoder, the result FIFO
// and the top level all use it.
package ced_pkg;

  // Default depth of the result FIFO. It must be at least 2.
  localparam int FIFO_DEPTH = 4;

  // Status codes carried with each result.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_EMPTY_HEX = 3'd2,
    ST_HEX_OVF   = 3'd3,
    ST_OCT_OVF   = 3'd4,
    ST_UNICODE   = 3'd5,
    ST_UNEXP_END = 3'd6
  } status_t;

  // Parser modes, one-hot.
  typedef enum logic [5:0] {
    MODE_START   = 6'b000001,
    MODE_BSLASH  = 6'b000010,
    MODE_HEX     = 6'b000100,
    MODE_UNICODE = 6'b001000,
    MODE_OCT0    = 6'b010000,
    MODE_OCT1    = 6'b100000
  } mode_t;

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    status_t    status;
    logic       last;
  } result_t;

  // Everything the decoder produces for one input item: up to two results.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } dec_out_t;

  // Characters the parser looks for.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U_LO   = 8'h75;
  localparam logic [7:0] CH_U_UP   = 8'h55;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  // True for 0-7.
  function automatic logic is_oct(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_SEVEN);
  endfunction

  // True for 0-9, a-f and A-F.
  function automatic logic is_hex(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) ||
           ((b >= 8'h61) && (b <= 8'h66)) ||
           ((b >= 8'h41) && (b <= 8'h46));
  endfunction

  // Value of a hex digit; meaningful only when is_hex holds.
  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] t;
    if (b <= 8'h39) begin
      t = b - 8'h30;
    end else if (b >= 8'h61) begin
      t = b - 8'h57;
    end else begin
      t = b - 8'h37;
    end
    return t[3:0];
  endfunction

  // Result for a simple escape letter: known letters map to their control byte or,
  // for quote, question mark and backslash, to themselves; anything else passes through flagged as unknown.
  function automatic result_t escape_letter(input logic [7:0] b);
    result_t r;
    r          = '0;
    r.has_byte = 1'b1;
    r.status   = ST_OK;
    unique case (b)
      8'h27, 8'h22, 8'h3F, 8'h5C: r.data = b;
      8'h61: r.data = 8'd7;
      8'h62: r.data = 8'd8;
      8'h66: r.data = 8'd12;
      8'h6E: r.data = 8'd10;
      8'h72: r.data = 8'd13;
      8'h74: r.data = 8'd9;
      8'h76: r.data = 8'd11;
      default: begin
        r.data   = b;
        r.status = ST_UNKNOWN;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: design/ced_decode.sv
// Escape sequence parser: mode and digit registers plus the single-pass
// next-state and result logic for one input item.
// Depends on ced_pkg.
module ced_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              end_of_text,
  output ced_pkg::dec_out_t res
);

  ced_pkg::mode_t mode, mode_next;
  logic [8:0]     digit_value, digit_value_next;
  logic           hex_overflow, hex_overflow_next;
  logic           digits_seen, digits_seen_next;

  ced_pkg::result_t fin;
  ced_pkg::result_t plain;
  ced_pkg::result_t r0, r1;
  logic [1:0]       cnt;
  logic [8:0]       oct_value;

  // Result that closes the run in progress, and the result for a plain byte.
  always_comb begin
    fin   = '0;
    plain = '0;
    unique case (mode)
      ced_pkg::MODE_HEX: begin
        if (digits_seen) begin
          fin.data     = digit_value[7:0];
          fin.has_byte = 1'b1;
          fin.status   = hex_overflow ? ced_pkg::ST_HEX_OVF : ced_pkg::ST_OK;
        end else begin
          fin.status   = ced_pkg::ST_EMPTY_HEX;
        end
      end
      ced_pkg::MODE_UNICODE: fin.status = ced_pkg::ST_UNICODE;
      ced_pkg::MODE_OCT0, ced_pkg::MODE_OCT1: begin
        fin.data     = digit_value[7:0];
        fin.has_byte = 1'b1;
        fin.status   = digit_value[8] ? ced_pkg::ST_OCT_OVF : ced_pkg::ST_OK;
      end
      default: fin = '0;
    endcase
    plain.data     = in_byte;
    plain.has_byte = 1'b1;
    plain.status   = ced_pkg::ST_OK;
  end

  assign oct_value = {digit_value[5:0], in_byte[2:0]};

  // Next state and the results caused by this item.
  always_comb begin
    mode_next         = mode;
    digit_value_next  = digit_value;
    hex_overflow_next = hex_overflow;
    digits_seen_next  = digits_seen;
    r0  = '0;
    r1  = '0;
    cnt = 2'd0;
    if (end_of_text) begin
      // End of text: close whatever is open and start over.
      mode_next         = ced_pkg::MODE_START;
      digit_value_next  = '0;
      hex_overflow_next = 1'b0;
      digits_seen_next  = 1'b0;
      if (mode == ced_pkg::MODE_BSLASH) begin
        r0.status = ced_pkg::ST_UNEXP_END;
        cnt       = 2'd1;
      end else if (mode != ced_pkg::MODE_START) begin
        r0  = fin;
        cnt = 2'd1;
      end
    end else begin
      unique case (mode)
        ced_pkg::MODE_BSLASH: begin
          digit_value_next  = '0;
          hex_overflow_next = 1'b0;
          digits_seen_next  = 1'b0;
          if (in_byte == ced_pkg::CH_X) begin
            mode_next = ced_pkg::MODE_HEX;
          end else if (in_byte == ced_pkg::CH_U_LO || in_byte == ced_pkg::CH_U_UP) begin
            mode_next = ced_pkg::MODE_UNICODE;
          end else if (ced_pkg::is_oct(in_byte)) begin
            mode_next        = ced_pkg::MODE_OCT0;
            digit_value_next = {6'd0, in_byte[2:0]};
          end else begin
            mode_next = ced_pkg::MODE_START;
            r0        = ced_pkg::escape_letter(in_byte);
            cnt       = 2'd1;
          end
        end
        ced_pkg::MODE_HEX, ced_pkg::MODE_UNICODE,
        ced_pkg::MODE_OCT0, ced_pkg::MODE_OCT1: begin
          if (mode == ced_pkg::MODE_HEX && ced_pkg::is_hex(in_byte)) begin
            // Accumulate a hex digit, keeping the low byte.
            if (digit_value[8:4] != 5'd0) begin
              hex_overflow_next = 1'b1;
            end
            digit_value_next = {1'b0, digit_value[3:0], ced_pkg::hex_val(in_byte)};
            digits_seen_next = 1'b1;
          end else if (mode == ced_pkg::MODE_UNICODE && ced_pkg::is_hex(in_byte)) begin
            // Unicode digits are swallowed.
            mode_next = mode;
          end else if (mode == ced_pkg::MODE_OCT0 && ced_pkg::is_oct(in_byte)) begin
            mode_next        = ced_pkg::MODE_OCT1;
            digit_value_next = oct_value;
          end else if (mode == ced_pkg::MODE_OCT1 && ced_pkg::is_oct(in_byte)) begin
            // Third octal digit closes the run.
            r0.data           = oct_value[7:0];
            r0.has_byte       = 1'b1;
            r0.status         = oct_value[8] ? ced_pkg::ST_OCT_OVF : ced_pkg::ST_OK;
            cnt               = 2'd1;
            mode_next         = ced_pkg::MODE_START;
            digit_value_next  = '0;
            hex_overflow_next = 1'b0;
            digits_seen_next  = 1'b0;
          end else begin
            // Terminator: close the run, then treat the byte as plain text.
            r0                = fin;
            digit_value_next  = '0;
            hex_overflow_next = 1'b0;
            digits_seen_next  = 1'b0;
            if (in_byte == ced_pkg::CH_BSLASH) begin
              mode_next = ced_pkg::MODE_BSLASH;
              cnt       = 2'd1;
            end else begin
              mode_next = ced_pkg::MODE_START;
              r1        = plain;
              cnt       = 2'd2;
            end
          end
        end
        default: begin
          if (in_byte == ced_pkg::CH_BSLASH) begin
            mode_next = ced_pkg::MODE_BSLASH;
          end else begin
            mode_next = ced_pkg::MODE_START;
            r0        = plain;
            cnt       = 2'd1;
          end
        end
      endcase
    end
    // Mark the final result of this item.
    if (cnt == 2'd1) begin
      r0.last = 1'b1;
    end else if (cnt == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign res.cnt = cnt;
  assign res.r0  = r0;
  assign res.r1  = r1;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ced_pkg::MODE_START;
      digit_value  <= '0;
      hex_overflow <= 1'b0;
      digits_seen  <= 1'b0;
    end else if (fire) begin
      mode         <= mode_next;
      digit_value  <= digit_value_next;
      hex_overflow <= hex_overflow_next;
      digits_seen  <= digits_seen_next;
    end
  end

endmodule

FILE: design/ced_result_fifo.sv
// Small result FIFO that takes up to two results per cycle and hands out one
// per transfer on the output stream.
// Depends on ced_pkg.
module ced_result_fifo #(
  parameter int Depth = ced_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_en,
  input  ced_pkg::dec_out_t push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output ced_pkg::result_t  head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ced_pkg::result_t entries [Depth];
  logic [PtrW-1:0]  wr_ptr, wr_ptr_next, wr_ptr_inc, rd_ptr, rd_ptr_inc;
  logic [CntW-1:0]  count, count_next;
  logic [CntW-1:0]  push_n;
  logic             pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign room       = (count <= CntW'(Depth - 2));
  assign out_valid  = (count != '0);
  assign head       = entries[rd_ptr];
  assign pop        = out_valid && out_ready;
  assign wr_ptr_inc = ptr_inc(wr_ptr);
  assign rd_ptr_inc = ptr_inc(rd_ptr);
  assign push_n     = push_en ? CntW'(push.cnt) : '0;

  // Pointer and fill count update.
  always_comb begin
    count_next  = count + push_n - (pop ? CntW'(1) : '0);
    wr_ptr_next = wr_ptr;
    if (push_n == CntW'(1)) begin
      wr_ptr_next = wr_ptr_inc;
    end else if (push_n == CntW'(2)) begin
      wr_ptr_next = ptr_inc(wr_ptr_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr_inc;
      end
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push_n != '0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push_n == CntW'(2)) begin
      entries[wr_ptr_inc] <= push.r1;
    end
  end

  // The fill count never goes past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("result FIFO count exceeds depth");

  // A push only happens when there is room for two results.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_en |-> room)
    else $error("push into result FIFO without room");

  // An empty FIFO that pushes nothing stays empty if nothing is popped.
  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    (count == '0) && !push_en |=> (count == '0))
    else $error("result FIFO count changed without a push");

endmodule

FILE: design/c_escape_sequence_decoder_top.sv
// Path: a byte passes through the input register, then is decoded into the
// result FIFO, which drives the output.
// Throughput: one byte per cycle while the result FIFO has room; a byte that
// ends a run with two results takes the single output port for two transfers.
// Reset: rst is synchronous; it returns the parser to plain text, empties the
// FIFO and drops the input register.
module c_escape_sequence_decoder_top #(
  parameter int FifoDepth = ced_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tuser,   // [0] end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [3:0] m_tuser,   // [0] has_byte, [3:1] status
  output logic       m_tlast    // last
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_eot;
  logic              room;
  logic              fire;
  ced_pkg::dec_out_t dec;
  ced_pkg::result_t  head;

  assign fire     = in_valid && room;
  assign s_tready = !in_valid || fire;

  // Input register: reloads whenever the held byte is decoded or it is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eot  <= s_tuser;
    end
  end

  ced_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .in_byte     (in_byte),
    .end_of_text (in_eot),
    .res         (dec)
  );

  ced_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_en   (fire),
    .push      (dec),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .head      (head)
  );

  // Output stream fields.
  assign m_tdata = head.data;
  assign m_tuser = {head.status, head.has_byte};
  assign m_tlast = head.last;

  // A held byte that is not decoded stays in the input register.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_byte) && $stable(in_eot))
    else $error("input register lost a byte while stalled");

  // A single result is always the last one of its byte.
  a_one_last: assert property (@(posedge clk) disable iff (rst)
    fire && (dec.cnt == 2'd1) |-> dec.r0.last)
    else $error("single result not marked last");

  // With two results only the second is marked last.
  a_two_last: assert property (@(posedge clk) disable iff (rst)
    fire && (dec.cnt == 2'd2) |-> dec.r1.last && !dec.r0.last)
    else $error("two results marked last wrongly");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for c_escape_sequence_decoder_top: drives text bytes and
// end-of-text marks over the input stream and checks every decoded result in order.
// Depends on ced_pkg and the decoder top level; a directed table runs first, then random text.
module testbench;

  localparam int RANDOM_ITEMS = 930;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_PRINTS   = 40;
  localparam int HOLD_CYCLES  = 80;
  localparam int TAIL_CYCLES  = 8;

  // How a row of the directed table is checked.
  typedef enum {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;

  // Receiver stall styles.
  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_style_t;

  typedef struct {
    logic [7:0]       b;
    logic             eot;
    row_check_t       check;
    ced_pkg::result_t want;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] in_byte
  logic       s_tuser;   // [0] end_of_text
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] out_byte
  logic [3:0] m_tuser;   // [0] has_byte, [3:1] status
  logic       m_tlast;

  // Decoder state as the checker tracks it.
  ced_pkg::mode_t dec_mode;
  logic [8:0]     dec_value;
  logic           dec_hex_ovf;
  logic           dec_digits;

  ced_pkg::result_t step_out[$];
  ced_pkg::result_t pending_decodes[$];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  items_sent   = 0;
  int  cycle_count  = 0;
  int  burst_left   = 0;
  bit  hold_req     = 1'b0;

  logic [7:0] escape_letters [11] = '{"'", "\"", "?", "\\", "a", "b", "f", "n", "r", "t", "v"};

  stim_row_t directed[$];

  c_escape_sequence_decoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  function automatic int hex_digit_value(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic void emit_result(logic [7:0] data, logic has, ced_pkg::status_t st);
    ced_pkg::result_t r;
    r.data     = has ? data : 8'h00;
    r.has_byte = has;
    r.status   = st;
    r.last     = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void clear_run();
    dec_mode    = ced_pkg::MODE_START;
    dec_value   = '0;
    dec_hex_ovf = 1'b0;
    dec_digits  = 1'b0;
  endfunction

  // A byte in plain text: a backslash opens an escape, anything else passes.
  function automatic void take_plain(logic [7:0] b);
    if (b == "\\") begin
      dec_mode = ced_pkg::MODE_BSLASH;
    end else begin
      emit_result(b, 1'b1, ced_pkg::ST_OK);
    end
  endfunction

  // Close an open hex, unicode or octal run and go back to plain text.
  function automatic void close_run();
    case (dec_mode)
      ced_pkg::MODE_HEX: begin
        if (!dec_digits) begin
          emit_result(8'h00, 1'b0, ced_pkg::ST_EMPTY_HEX);
        end else begin
          emit_result(dec_value[7:0], 1'b1,
                      dec_hex_ovf ? ced_pkg::ST_HEX_OVF : ced_pkg::ST_OK);
        end
      end
      ced_pkg::MODE_UNICODE: emit_result(8'h00, 1'b0, ced_pkg::ST_UNICODE);
      ced_pkg::MODE_OCT0, ced_pkg::MODE_OCT1: begin
        emit_result(dec_value[7:0], 1'b1,
                    (dec_value >= 9'd256) ? ced_pkg::ST_OCT_OVF : ced_pkg::ST_OK);
      end
      default: ;
    endcase
    clear_run();
  endfunction

  // Single-letter escapes map to control bytes; unknown letters pass with a warning.
  function automatic void simple_escape(logic [7:0] b);
    logic [7:0]       v;
    ced_pkg::status_t st;
    v  = b;
    st = ced_pkg::ST_OK;
    case (b)
      "'", "\"", "?", "\\": v = b;
      "a": v = 8'd7;
      "b": v = 8'd8;
      "f": v = 8'd12;
      "n": v = 8'd10;
      "r": v = 8'd13;
      "t": v = 8'd9;
      "v": v = 8'd11;
      default: st = ced_pkg::ST_UNKNOWN;
    endcase
    dec_mode = ced_pkg::MODE_START;
    emit_result(v, 1'b1, st);
  endfunction

  // Advance the tracked state by one accepted input; results land in step_out.
  function automatic void decode_item(logic [7:0] b, logic eot);
    int d;
    step_out.delete();
    if (eot) begin
      if (dec_mode == ced_pkg::MODE_BSLASH) begin
        emit_result(8'h00, 1'b0, ced_pkg::ST_UNEXP_END);
      end else if (dec_mode != ced_pkg::MODE_START) begin
        close_run();
      end
      clear_run();
    end else begin
      case (dec_mode)
        ced_pkg::MODE_BSLASH: begin
          if (b == "x") begin
            clear_run();
            dec_mode = ced_pkg::MODE_HEX;
          end else if (b == "u" || b == "U") begin
            clear_run();
            dec_mode = ced_pkg::MODE_UNICODE;
          end else if (b >= "0" && b <= "7") begin
            clear_run();
            dec_value = {6'd0, b[2:0]};
            dec_mode  = ced_pkg::MODE_OCT0;
          end else begin
            simple_escape(b);
          end
        end
        ced_pkg::MODE_HEX: begin
          d = hex_digit_value(b);
          if (d >= 0) begin
            // Only the low byte is kept; a value that is already 16 or more overflows.
            if (dec_value >= 9'd16) dec_hex_ovf = 1'b1;
            dec_value  = {1'b0, dec_value[3:0], d[3:0]};
            dec_digits = 1'b1;
          end else begin
            close_run();
            take_plain(b);
          end
        end
        ced_pkg::MODE_UNICODE: begin
          if (hex_digit_value(b) < 0) begin
            close_run();
            take_plain(b);
          end
        end
        ced_pkg::MODE_OCT0, ced_pkg::MODE_OCT1: begin
          if (b >= "0" && b <= "7") begin
            dec_value = {dec_value[5:0], b[2:0]};
            if (dec_mode == ced_pkg::MODE_OCT0) begin
              dec_mode = ced_pkg::MODE_OCT1;
            end else begin
              close_run();
            end
          end else begin
            close_run();
            take_plain(b);
          end
        end
        default: begin
          dec_mode = ced_pkg::MODE_START;
          take_plain(b);
        end
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------

  function automatic stim_row_t row_model(logic [7:0] b, logic eot);
    stim_row_t r;
    r.b     = b;
    r.eot   = eot;
    r.check = CHK_MODEL;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t row_quiet(logic [7:0] b, logic eot);
    stim_row_t r;
    r       = row_model(b, eot);
    r.check = CHK_NONE;
    return r;
  endfunction

  function automatic stim_row_t row_known(logic [7:0] b, logic eot, logic [7:0] data,
                                          logic has, ced_pkg::status_t st);
    stim_row_t r;
    r               = row_model(b, eot);
    r.check         = CHK_ONE;
    r.want.data     = data;
    r.want.has_byte = has;
    r.want.status   = st;
    r.want.last     = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  task automatic idle_for(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Bursts of random length; roughly half are long stretches with no gap at all.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 1) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      idle_for($urandom_range(1, 6));
    end
  endtask

  // Offer one item, wait for its transfer, then record what it should produce.
  task automatic send_row(stim_row_t r);
    s_tvalid <= 1'b1;
    s_tdata  <= r.b;
    s_tuser  <= r.eot;
    do @(posedge clk); while (!s_tready);
    decode_item(r.b, r.eot);
    case (r.check)
      CHK_MODEL: foreach (step_out[i]) pending_decodes.push_back(step_out[i]);
      CHK_ONE:   pending_decodes.push_back(r.want);
      default: ;
    endcase
    items_sent++;
    pace();
  endtask

  task automatic send_byte(logic [7:0] b);
    send_row(row_model(b, 1'b0));
  endtask

  // End of text; the byte lane carries junk the block must ignore.
  task automatic send_end();
    send_row(row_model(8'($urandom_range(0, 255)), 1'b1));
  endtask

  // Stop offering, then wait on the clock until every result is back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_decodes.size() != 0);
  endtask

  function automatic logic [7:0] random_hex_char();
    int n;
    n = $urandom_range(0, 21);
    if (n < 10) return 8'("0" + n);
    if (n < 16) return 8'("a" + n - 10);
    return 8'("A" + n - 16);
  endfunction

  // One random piece of text: mostly well-formed escapes, some noise.
  task automatic send_random_chunk();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 45) begin
      send_byte("\\");
      if ($urandom_range(0, 3) == 0) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(escape_letters[$urandom_range(0, 10)]);
      end
    end else if (kind < 60) begin
      send_byte("\\");
      send_byte("x");
      n = $urandom_range(0, 5);
      repeat (n) send_byte(random_hex_char());
      if ($urandom_range(0, 4) == 0) send_end();
    end else if (kind < 75) begin
      send_byte("\\");
      n = $urandom_range(1, 3);
      repeat (n) send_byte(8'("0" + $urandom_range(0, 7)));
      if ($urandom_range(0, 4) == 0) send_end();
    end else if (kind < 85) begin
      send_byte("\\");
      send_byte(($urandom_range(0, 1) == 0) ? "u" : "U");
      n = $urandom_range(0, 6);
      repeat (n) send_byte(random_hex_char());
      if ($urandom_range(0, 4) == 0) send_end();
    end else if (kind < 92) begin
      send_end();
    end else if (kind < 96) begin
      send_byte("\\");
      send_end();
    end else begin
      // Noise with a high share of backslashes.
      n = $urandom_range(1, 4);
      repeat (n) send_byte(($urandom_range(0, 1) == 0) ? "\\" : 8'($urandom_range(0, 255)));
    end
  endtask

  // Main stimulus.
  initial begin : stimulus
    bit held;
    bit paused;
    held     = 1'b0;
    paused   = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tuser  <= 1'b0;
    clear_run();

    directed = '{
      row_known("A", 1'b0, "A", 1'b1, ced_pkg::ST_OK),
      row_known(8'h00, 1'b0, 8'h00, 1'b1, ced_pkg::ST_OK),
      row_known(8'hFF, 1'b0, 8'hFF, 1'b1, ced_pkg::ST_OK),
      row_quiet("\\", 1'b0),
      row_known("n", 1'b0, 8'h0A, 1'b1, ced_pkg::ST_OK),
      row_quiet("\\", 1'b0),
      row_known("q", 1'b0, "q", 1'b1, ced_pkg::ST_UNKNOWN),
      // Hex value that runs past one byte, ended by a plain letter.
      row_quiet("\\", 1'b0),
      row_quiet("x", 1'b0),
      row_quiet("F", 1'b0),
      row_quiet("f", 1'b0),
      row_quiet("1", 1'b0),
      row_model("z", 1'b0),
      // Three octal digits worth more than a byte.
      row_quiet("\\", 1'b0),
      row_quiet("7", 1'b0),
      row_quiet("7", 1'b0),
      row_known("7", 1'b0, 8'hFF, 1'b1, ced_pkg::ST_OCT_OVF),
      // Unicode run ended by punctuation.
      row_quiet("\\", 1'b0),
      row_quiet("U", 1'b0),
      row_quiet("1", 1'b0),
      row_model("!", 1'b0),
      // Text ending inside an escape, in plain text, and after an empty hex.
      row_quiet("\\", 1'b0),
      row_known(8'h5A, 1'b1, 8'h00, 1'b0, ced_pkg::ST_UNEXP_END),
      row_quiet(8'hFF, 1'b1),
      row_quiet("\\", 1'b0),
      row_quiet("x", 1'b0),
      row_known(8'h00, 1'b1, 8'h00, 1'b0, ced_pkg::ST_EMPTY_HEX)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_row(directed[i]);

    while (items_sent < directed.size() + RANDOM_ITEMS) begin
      // Long receiver hold-off while input keeps flowing, so the block backs up.
      if (!held && items_sent > 350) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && items_sent > 650) begin
        paused = 1'b1;
        wait_drained();
      end
      send_random_chunk();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver
  // ---------------------------------------------------------------------------

  initial begin : receiver
    rx_style_t style;
    int        span;
    int        hold_left;
    int        phase;
    style     = RX_ALWAYS;
    span      = 0;
    hold_left = 0;
    phase     = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (span == 0) begin
        style = rx_style_t'($urandom_range(0, 2));
        span  = $urandom_range(20, 200);
      end
      span--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (style)
          RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: m_tready <= (phase % 5) < 2;
          default:     m_tready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
    end
  endtask

  // Each output transfer is compared with the oldest outstanding decode.
  always @(posedge clk) begin : check_output
    ced_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("with nothing outstanding", {m_tlast, m_tuser, m_tdata}, 0);
      end else begin
        want = pending_decodes.pop_front();
        if (m_tdata !== want.data) report_mismatch("out_byte", m_tdata, want.data);
        if (m_tuser[0] !== want.has_byte) report_mismatch("has_byte", m_tuser[0], want.has_byte);
        if (m_tuser[3:1] !== want.status) report_mismatch("status", m_tuser[3:1], want.status);
        if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
      end
      results_seen++;
    end
  end

endmodule

FILE: files.f
design/ced_pkg.sv
design/ced_decode.sv
design/ced_result_fifo.sv
design/c_escape_sequence_decoder_top.sv
tb/testbench.sv
